>>> rtl/ffc_pkg.sv
// shared types, constants and helpers of the four-function calculator core
package ffc_pkg;

  localparam int unsigned DefWidth  = 16;
  localparam int unsigned MaxDigits = 5;
  localparam int unsigned BcdW      = 4 * MaxDigits;
  localparam int unsigned DigCntW   = $clog2(MaxDigits + 1);
  localparam int unsigned CmdDepth  = 2;

  typedef enum logic [1:0] {
    KIND_DIGIT  = 2'd0,
    KIND_OP     = 2'd1,
    KIND_EQUALS = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // work handed from front to back
  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_SHOW    = 2'd1,
    CMD_CALC    = 2'd2,
    CMD_DIVZERO = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_CONV,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  digit;
    op_e         op_code;
  } key_t;

  typedef struct packed {
    logic [3:0]  digit_out;
    logic        negative;
    logic        error;
    logic        last;
  } result_t;

  typedef struct packed {
    cmd_e        cmd;
    op_e         op;
  } cmd_ctrl_t;

  // number of digits to show: highest non-zero digit, at least one,
  // all of them once the value has run past the digit register
  function automatic logic [DigCntW-1:0] dig_count(input logic [BcdW-1:0] bcd,
                                                   input logic            ovf);
    logic [DigCntW-1:0] n;
    n = DigCntW'(1);
    for (int i = 0; i < MaxDigits; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        n = DigCntW'(i + 1);
      end
    end
    if (ovf) begin
      n = DigCntW'(MaxDigits);
    end
    return n;
  endfunction

endpackage

>>> rtl/ffc_cmd_fifo.sv
// short command queue between the key front end and the arithmetic back end
module ffc_cmd_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o,
  output logic         full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == CntW'(0));
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? PtrW'(0) : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? PtrW'(0) : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/ffc_front.sv
// key front end: operand entry, pending operator and command issue
module ffc_front import ffc_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             key_valid_i,
  input  key_t             key_i,
  output logic             cmd_push_o,
  output cmd_ctrl_t        cmd_ctrl_o,
  output logic [WIDTH-1:0] cmd_a_o,
  output logic [WIDTH-1:0] cmd_b_o
);

  logic [WIDTH-1:0] first_q, first_d;
  logic [WIDTH-1:0] second_q, second_d;
  logic             op_valid_q, op_valid_d;
  op_e              op_q, op_d;
  logic             on_second_q, on_second_d;
  logic [WIDTH-1:0] entry_q, entry_x10, entry_next;

  // operand being typed, times ten plus the new digit
  assign entry_q    = on_second_q ? second_q : first_q;
  assign entry_x10  = (entry_q << 3) + (entry_q << 1);
  assign entry_next = entry_x10 + WIDTH'(key_i.digit);

  assign cmd_a_o = first_q;
  assign cmd_b_o = second_q;

  // key decode
  always_comb begin
    first_d     = first_q;
    second_d    = second_q;
    op_valid_d  = op_valid_q;
    op_d        = op_q;
    on_second_d = on_second_q;
    cmd_push_o  = 1'b0;
    cmd_ctrl_o  = '{cmd: CMD_SHOW, op: op_q};
    if (key_valid_i) begin
      case (key_i.kind)
        KIND_DIGIT: begin
          if (key_i.digit <= 4'd9) begin
            if (on_second_q) begin
              second_d = entry_next;
            end else begin
              first_d = entry_next;
            end
          end
        end
        KIND_OP: begin
          on_second_d = 1'b1;
          op_valid_d  = 1'b1;
          op_d        = key_i.op_code;
        end
        KIND_EQUALS: begin
          cmd_push_o = 1'b1;
          if (!op_valid_q) begin
            cmd_ctrl_o.cmd = CMD_SHOW;
          end else if (op_q == OP_DIV && second_q == '0) begin
            cmd_ctrl_o.cmd = CMD_DIVZERO;
            first_d        = '0;
            second_d       = '0;
            op_valid_d     = 1'b0;
            on_second_d    = 1'b0;
          end else begin
            cmd_ctrl_o.cmd = CMD_CALC;
          end
        end
        KIND_CLEAR: begin
          cmd_push_o     = 1'b1;
          cmd_ctrl_o.cmd = CMD_CLEAR;
          first_d        = '0;
          second_d       = '0;
          op_valid_d     = 1'b0;
          on_second_d    = 1'b0;
        end
        default: begin
          cmd_push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= '0;
      second_q    <= '0;
      op_valid_q  <= 1'b0;
      op_q        <= OP_ADD;
      on_second_q <= 1'b0;
    end else begin
      first_q     <= first_d;
      second_q    <= second_d;
      op_valid_q  <= op_valid_d;
      op_q        <= op_d;
      on_second_q <= on_second_d;
    end
  end

endmodule

>>> rtl/ffc_back.sv
// arithmetic back end: operation, serial divide, binary to decimal, digit output
module ffc_back import ffc_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_empty_i,
  input  cmd_ctrl_t        cmd_ctrl_i,
  input  logic [WIDTH-1:0] cmd_a_i,
  input  logic [WIDTH-1:0] cmd_b_i,
  output logic             cmd_pop_o,
  output logic             res_valid_o,
  output result_t          res_o,
  input  logic             res_pop_i
);

  localparam int unsigned CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  back_state_e        state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0]   bin_q, bin_d;
  logic [WIDTH-1:0]   rem_q, rem_d;
  logic [WIDTH-1:0]   dvs_q, dvs_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic               ovf_q, ovf_d;
  logic [DigCntW-1:0] idx_q, idx_d;
  logic               neg_q, neg_d;
  logic               err_q, err_d;
  logic [WIDTH-1:0]   shown_q, shown_d;
  logic               shown_neg_q, shown_neg_d;
  result_t            out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [2*WIDTH-1:0] prod;
  logic               a_ge_b;
  logic [WIDTH:0]     div_shift, div_diff;
  logic [BcdW-1:0]    bcd_adj;
  logic               out_free;
  logic               last_step;

  assign prod      = cmd_a_i * cmd_b_i;
  assign a_ge_b    = (cmd_a_i >= cmd_b_i);
  assign div_shift = {rem_q, bin_q[WIDTH-1]};
  assign div_diff  = div_shift - {1'b0, dvs_q};
  assign last_step = (cnt_q == CntW'(WIDTH - 1));
  assign out_free  = !out_valid_q || res_pop_i;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < MaxDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                   : bcd_q[4*i +: 4];
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    bin_d       = bin_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    bcd_d       = bcd_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    err_d       = err_q;
    shown_d     = shown_q;
    shown_neg_d = shown_neg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_pop_i;
    cmd_pop_o   = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cnt_d     = '0;
          bcd_d     = '0;
          ovf_d     = 1'b0;
          err_d     = 1'b0;
          case (cmd_ctrl_i.cmd)
            CMD_CLEAR: begin
              shown_d     = '0;
              shown_neg_d = 1'b0;
            end
            CMD_SHOW: begin
              bin_d   = shown_q;
              neg_d   = shown_neg_q;
              state_d = B_CONV;
            end
            CMD_DIVZERO: begin
              shown_d     = '0;
              shown_neg_d = 1'b0;
              neg_d       = 1'b0;
              err_d       = 1'b1;
              idx_d       = '0;
              state_d     = B_EMIT;
            end
            CMD_CALC: begin
              neg_d       = 1'b0;
              shown_neg_d = 1'b0;
              state_d     = B_CONV;
              case (cmd_ctrl_i.op)
                OP_ADD: begin
                  bin_d = cmd_a_i + cmd_b_i;
                end
                OP_SUB: begin
                  bin_d       = a_ge_b ? cmd_a_i - cmd_b_i : cmd_b_i - cmd_a_i;
                  neg_d       = !a_ge_b;
                  shown_neg_d = !a_ge_b;
                end
                OP_MUL: begin
                  bin_d = prod[WIDTH-1:0];
                end
                OP_DIV: begin
                  bin_d   = cmd_a_i;
                  rem_d   = '0;
                  dvs_d   = cmd_b_i;
                  state_d = B_DIV;
                end
                default: begin
                  bin_d = cmd_a_i;
                end
              endcase
              shown_d = bin_d;
            end
            default: begin
              state_d = B_IDLE;
            end
          endcase
        end
      end
      // restoring divide, one quotient bit a cycle into the dividend register
      B_DIV: begin
        if (!div_diff[WIDTH]) begin
          rem_d = div_diff[WIDTH-1:0];
        end else begin
          rem_d = div_shift[WIDTH-1:0];
        end
        bin_d = {bin_q[WIDTH-2:0], !div_diff[WIDTH]};
        cnt_d = cnt_q + CntW'(1);
        if (last_step) begin
          shown_d = bin_d;
          cnt_d   = '0;
          state_d = B_CONV;
        end
      end
      // shift-add-three conversion, low digits only, overflow kept sticky
      B_CONV: begin
        bcd_d = {bcd_adj[BcdW-2:0], bin_q[WIDTH-1]};
        ovf_d = ovf_q | bcd_adj[BcdW-1];
        bin_d = bin_q << 1;
        cnt_d = cnt_q + CntW'(1);
        if (last_step) begin
          idx_d   = dig_count(bcd_d, ovf_d) - DigCntW'(1);
          state_d = B_EMIT;
        end
      end
      // digits out, most significant first
      B_EMIT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.digit_out = bcd_q[4*idx_q +: 4];
          out_d.negative  = neg_q;
          out_d.error     = err_q;
          out_d.last      = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = B_IDLE;
          end else begin
            idx_d = idx_q - DigCntW'(1);
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      shown_q     <= '0;
      shown_neg_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      shown_q     <= shown_d;
      shown_neg_q <= shown_neg_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    bin_q <= bin_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    bcd_q <= bcd_d;
    ovf_q <= ovf_d;
    idx_q <= idx_d;
    neg_q <= neg_d;
    err_q <= err_d;
    out_q <= out_d;
  end

endmodule

>>> rtl/four_function_calculator_core.sv
// top level of the four-function calculator core
//
// Key events enter through a queue-style port: key_i is taken at a rising
// edge with push high and full low. Digit and operator keys are absorbed by
// the front end at once and give no result. Equals and clear keys become
// commands in a two-entry queue that the back end drains one at a time.
// Results leave through a queue-style port: while empty is low, result_o
// holds the oldest digit, taken at an edge with pop high; the run ends on
// the item with last set.
// An equals key for add, subtract, multiply or a repeated show passes
// through the serial binary to decimal converter, one bit a cycle; a
// divide first passes through the serial divider, one bit a cycle, and
// then through the converter. A divide by zero gives its error item
// without either step. One command is worked on at a time in the back
// end.
// When the receiver stalls, the back end holds its next digit, the queue
// fills and full rises; keys are then held off.
// Reset clears operands, pending operator, shown value and the queue.
module four_function_calculator_core import ffc_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  key_t    key_i,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  localparam int unsigned CmdW = $bits(cmd_ctrl_t) + 2 * WIDTH;

  logic             key_accept;
  logic             cmd_push, cmd_pop, cmd_empty, cmd_full;
  cmd_ctrl_t        fe_ctrl, hd_ctrl;
  logic [WIDTH-1:0] fe_a, fe_b, hd_a, hd_b;
  logic [CmdW-1:0]  fifo_wdata, fifo_rdata;
  logic             res_valid;

  // key transfer
  assign full       = cmd_full;
  assign key_accept = push && !cmd_full;

  ffc_front #(
    .WIDTH (WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_valid_i (key_accept),
    .key_i       (key_i),
    .cmd_push_o  (cmd_push),
    .cmd_ctrl_o  (fe_ctrl),
    .cmd_a_o     (fe_a),
    .cmd_b_o     (fe_b)
  );

  // command queue
  assign fifo_wdata = {fe_ctrl, fe_a, fe_b};
  assign {hd_ctrl, hd_a, hd_b} = fifo_rdata;

  ffc_cmd_fifo #(
    .W     (CmdW),
    .DEPTH (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (fifo_wdata),
    .pop_i   (cmd_pop),
    .data_o  (fifo_rdata),
    .empty_o (cmd_empty),
    .full_o  (cmd_full)
  );

  ffc_back #(
    .WIDTH (WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_ctrl_i  (hd_ctrl),
    .cmd_a_i     (hd_a),
    .cmd_b_i     (hd_b),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (result_o),
    .res_pop_i   (pop)
  );

  assign empty = !res_valid;

  // an accepted equals or clear key is waiting in the queue next cycle
  a_cmd_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_accept && (key_i.kind == KIND_EQUALS || key_i.kind == KIND_CLEAR))
      |=> !cmd_empty)
    else $error("equals or clear key not queued");

  // an error item is a lone zero digit without sign
  a_error_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.error)
      |-> (result_o.last && !result_o.negative && result_o.digit_out == 4'd0))
    else $error("malformed error item");

  // shown digits are decimal
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.digit_out <= 4'd9))
    else $error("result digit out of decimal range");

endmodule

>>> test/tb_four_function_calculator_core.sv
// self-checking testbench of the four-function calculator core
module tb_four_function_calculator_core import ffc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = DefWidth;

  // one entry of the key feed: a key, or a pause until every digit is back
  typedef struct {
    key_t key;
    bit   drain;
  } key_entry_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    push = 1'b0;
  logic    full;
  key_t    key = '0;
  logic    empty;
  logic    pop = 1'b0;
  result_t res;

  key_entry_t  key_feed[$];
  result_t     digits_due[$];
  int unsigned keys_taken = 0;
  int unsigned stim_count = 0;
  int unsigned mismatch_count = 0;
  bit          calm = 1'b0;
  bit          hold_long = 1'b0;

  // calculator state as predicted
  logic [W-1:0] first_opnd;
  logic [W-1:0] second_opnd;
  logic [W-1:0] shown_mag;
  logic         shown_neg;
  logic         on_second_opnd;
  logic         op_waiting;
  op_e          waiting_op;

  four_function_calculator_core #(
    .WIDTH(W)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .key_i   (key),
    .empty   (empty),
    .pop     (pop),
    .result_o(res)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // back to the reset state, as the clear key does
  function automatic void clear_calc();
    first_opnd     = '0;
    second_opnd    = '0;
    shown_mag      = '0;
    shown_neg      = 1'b0;
    on_second_opnd = 1'b0;
    op_waiting     = 1'b0;
    waiting_op     = OP_ADD;
  endfunction

  // queue the decimal digits of a value, most significant first
  function automatic void show_value(logic [W-1:0] v, logic neg);
    logic [3:0]   rev [MaxDigits];
    logic [W-1:0] rest;
    result_t      r;
    int           n;
    rest = v;
    n = 0;
    do begin
      rev[n] = 4'(rest % 10);
      rest = rest / 10;
      n++;
    end while (rest != 0 && n < MaxDigits);
    for (int k = 0; k < n; k++) begin
      r.digit_out = rev[n-1-k];
      r.negative  = neg;
      r.error     = 1'b0;
      r.last      = (k == n - 1);
      digits_due.push_back(r);
    end
  endfunction

  // predict the digits that one accepted key gives
  function automatic void calc_key(key_t k);
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] r;
    logic         neg;
    result_t      e;
    a = first_opnd;
    b = second_opnd;
    r = '0;
    neg = 1'b0;
    case (k.kind)
      KIND_DIGIT: begin
        if (k.digit <= 4'd9) begin
          if (on_second_opnd) begin
            second_opnd = W'(second_opnd * 10 + k.digit);
          end else begin
            first_opnd = W'(first_opnd * 10 + k.digit);
          end
        end
      end
      KIND_OP: begin
        on_second_opnd = 1'b1;
        op_waiting     = 1'b1;
        waiting_op     = k.op_code;
      end
      KIND_CLEAR: begin
        clear_calc();
      end
      default: begin
        if (!op_waiting) begin
          show_value(shown_mag, shown_neg);
        end else if (waiting_op == OP_DIV && b == '0) begin
          // divide by zero: one error item, then everything cleared
          e.digit_out = 4'd0;
          e.negative  = 1'b0;
          e.error     = 1'b1;
          e.last      = 1'b1;
          digits_due.push_back(e);
          clear_calc();
        end else begin
          case (waiting_op)
            OP_ADD: r = a + b;
            OP_SUB: begin
              if (a >= b) begin
                r = a - b;
              end else begin
                r = b - a;
                neg = 1'b1;
              end
            end
            OP_MUL: r = a * b;
            default: r = a / b;
          endcase
          shown_mag = r;
          shown_neg = neg;
          show_value(shown_mag, shown_neg);
        end
      end
    endcase
  endfunction

  // key feed helpers; a negative digit or operator means random filler
  task automatic add_key(kind_e kd, int dgt, int opc);
    key_entry_t ent;
    ent.drain       = 1'b0;
    ent.key.kind    = kd;
    ent.key.digit   = (dgt < 0) ? 4'($urandom_range(0, 15)) : 4'(dgt);
    ent.key.op_code = op_e'((opc < 0) ? $urandom_range(0, 3) : opc);
    key_feed.push_back(ent);
    if (!(kd == KIND_DIGIT && ent.key.digit > 4'd9)) begin
      stim_count++;
    end
  endtask

  task automatic add_number(int unsigned v);
    int unsigned scale;
    scale = 1;
    while (v / scale >= 10) scale *= 10;
    do begin
      add_key(KIND_DIGIT, int'((v / scale) % 10), -1);
      scale /= 10;
    end while (scale != 0);
  endtask

  function automatic int unsigned rand_operand();
    int unsigned len;
    len = $urandom_range(0, 5);
    if (len == 0) begin
      return 0;
    end
    return $urandom_range(0, 10 ** len - 1);
  endfunction

  // key driver
  always @(posedge clk_i) begin : drive_keys
    int unsigned gap_left;
    bit          next_push;
    key_entry_t  ent;
    if (!rst_ni) begin
      push <= 1'b0;
      gap_left = 0;
    end else begin
      if (push && !full) begin
        calc_key(key);
        keys_taken <= keys_taken + 1;
      end
      if (!push || !full) begin
        next_push = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (key_feed.size() != 0) begin
          if (key_feed[0].drain) begin
            if (digits_due.size() == 0) begin
              void'(key_feed.pop_front());
            end
          end else if (!calm && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 11) - 1;
          end else begin
            ent = key_feed.pop_front();
            key <= ent.key;
            next_push = 1'b1;
          end
        end
        push <= next_push;
      end
      calm <= (key_feed.size() < 30);
    end
  end

  // digit monitor and receiver stalls
  always @(posedge clk_i) begin : watch_digits
    int unsigned stall_left;
    result_t     e;
    if (!rst_ni) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        if (digits_due.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: digit transfer with none expected: digit %0d neg %b err %b last %b",
                     $realtime, res.digit_out, res.negative, res.error, res.last);
          end
          mismatch_count++;
        end else begin
          e = digits_due.pop_front();
          if (res.digit_out !== e.digit_out || res.negative !== e.negative ||
              res.error !== e.error || res.last !== e.last) begin
            if (mismatch_count < 10) begin
              $display("%0t: digit mismatch: expected %0d/%b/%b/%b got %0d/%b/%b/%b",
                       $realtime, e.digit_out, e.negative, e.error, e.last,
                       res.digit_out, res.negative, res.error, res.last);
            end
            mismatch_count++;
          end
        end
      end
      if (hold_long) begin
        pop <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // long receiver hold-off so that the block backs up and raises full
  initial begin
    while (keys_taken < 80) @(posedge clk_i);
    hold_long <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_long <= 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL four_function_calculator_core");
    $finish;
  end

  // key feed, reset and end of run
  initial begin : main_flow
    key_entry_t  pause;
    int unsigned sel;
    int unsigned guard;
    bit          paused;
    clear_calc();
    pause.key   = '0;
    pause.drain = 1'b1;
    paused      = 1'b0;

    // directed keys
    add_key(KIND_EQUALS, -1, -1);             // nothing pending, shows zero
    add_key(KIND_DIGIT, 15, -1);              // out-of-range digit, ignored
    add_number(99999);                        // wraps to the operand width
    add_key(KIND_OP, -1, OP_SUB);
    add_key(KIND_OP, -1, OP_MUL);
    add_key(KIND_OP, -1, OP_ADD);             // later operator replaces
    add_number(65535);
    add_key(KIND_EQUALS, -1, -1);             // sum wraps
    add_key(KIND_EQUALS, -1, -1);             // repeated equals
    add_key(KIND_OP, -1, OP_SUB);
    add_key(KIND_EQUALS, -1, -1);             // second larger, negative
    add_key(KIND_CLEAR, -1, -1);
    add_key(KIND_OP, -1, OP_DIV);
    add_key(KIND_EQUALS, -1, -1);             // divide by zero
    add_key(KIND_EQUALS, -1, -1);             // cleared, shows zero again
    add_number(7);
    add_key(KIND_OP, -1, OP_MUL);
    add_key(KIND_DIGIT, 10, -1);
    add_number(7);
    add_key(KIND_EQUALS, -1, -1);
    add_key(KIND_OP, -1, OP_SUB);
    add_key(KIND_EQUALS, -1, -1);             // equal difference, positive
    add_key(KIND_DIGIT, 0, -1);               // extends the second operand
    add_key(KIND_EQUALS, -1, -1);

    // random sequences, mostly well formed
    while (stim_count < 210) begin
      if (!paused && stim_count > 130) begin
        key_feed.push_back(pause);
        paused = 1'b1;
      end
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        if ($urandom_range(0, 3) != 0) begin
          add_number(rand_operand());
        end
        if ($urandom_range(0, 5) == 0) begin
          add_key(KIND_OP, -1, -1);
        end
        add_key(KIND_OP, -1, -1);
        add_number(rand_operand());
        add_key(KIND_EQUALS, -1, -1);
        if ($urandom_range(0, 3) == 0) begin
          add_key(KIND_EQUALS, -1, -1);
        end
        if ($urandom_range(0, 4) == 0) begin
          add_key(KIND_DIGIT, $urandom_range(0, 9), -1);
          add_key(KIND_EQUALS, -1, -1);
        end
      end else if (sel == 7) begin
        add_key(KIND_CLEAR, -1, -1);
      end else begin
        repeat ($urandom_range(1, 3)) add_key(kind_e'($urandom_range(0, 3)), -1, -1);
      end
    end

    // reset
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the feed to run dry and every digit to come back
    while (key_feed.size() != 0 || push) @(posedge clk_i);
    guard = 0;
    while (digits_due.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && digits_due.size() == 0) begin
      $display("PASS four_function_calculator_core");
    end else begin
      $display("FAIL four_function_calculator_core");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ffc_pkg.sv
rtl/ffc_cmd_fifo.sv
rtl/ffc_front.sv
rtl/ffc_back.sv
rtl/four_function_calculator_core.sv
test/tb_four_function_calculator_core.sv
